// ===== rtl/white_balance_gain_calculator_defines.svh =====
// Assertion macros for the white balance gain calculator.
// Included by the top level; no other dependencies.
`ifndef WHITE_BALANCE_GAIN_CALCULATOR_DEFINES_SVH
`define WHITE_BALANCE_GAIN_CALCULATOR_DEFINES_SVH

`ifndef SYNTH
// Combinational implication checked at every clock edge.
`define WBG_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");
// Condition in one cycle implies another in the next.
`define WBG_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define WBG_ASSERT_IMP(label, pre, post)
`define WBG_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ===== rtl/wbg_pkg.sv =====
// Shared types and constants for the white balance gain calculator.
// No dependencies.
package wbg_pkg;

  localparam int RATIO_SCALE_LOG2_DEF = 12;
  localparam int DIV_W = 32;

  localparam logic [15:0] RESET_TYP_RED   = 16'hccc;
  localparam logic [15:0] RESET_TYP_GREEN = 16'h6dc;
  localparam logic [15:0] RESET_TYP_BLUE  = 16'hac7;
  localparam logic [31:0] GAIN_UNITY      = 32'h100;
  localparam logic [31:0] GAIN_LIMIT      = 32'h1000;

  localparam logic [1:0] CFG_TYP_RED   = 2'd0;
  localparam logic [1:0] CFG_TYP_GREEN = 2'd1;
  localparam logic [1:0] CFG_TYP_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_GAIN  = 2'd1,
    ST_ZERO_RATIO = 2'd2,
    ST_RANGE      = 2'd3
  } status_e;

  // which channel ends up at unity
  typedef enum logic [1:0] {
    BR_GREEN = 2'd0,
    BR_RED   = 2'd1,
    BR_BLUE  = 2'd2
  } branch_e;

  typedef struct packed {
    logic valid;
    logic zero;
  } side1_t;

  typedef struct packed {
    logic        valid;
    status_e     status;
    branch_e     branch;
    logic [31:0] mul_x;
    logic [31:0] den_y;
  } side2_t;

  typedef struct packed {
    logic        valid;
    status_e     status;
    branch_e     branch;
    logic [31:0] q1;
    logic [31:0] q2;
  } side3_t;

endpackage

// ===== rtl/wbg_in_if.sv =====
// Input channel: one measured calibration triple per transaction.
// No dependencies.
interface wbg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] meas_red;
  logic [15:0] meas_green;
  logic [15:0] meas_blue;

  modport source (output valid, output meas_red, output meas_green, output meas_blue,
                  input ready);
  modport sink (input valid, input meas_red, input meas_green, input meas_blue,
                output ready);
endinterface

// ===== rtl/wbg_out_if.sv =====
// Output channel: gains, write flags and status per transaction.
// Depends on wbg_pkg.
interface wbg_out_if
  import wbg_pkg::*;
;
  logic        valid;
  logic        ready;
  logic [11:0] gain_red;
  logic [11:0] gain_green;
  logic [11:0] gain_blue;
  logic        write_red;
  logic        write_green;
  logic        write_blue;
  status_e     status;

  modport source (output valid, output gain_red, output gain_green, output gain_blue,
                  output write_red, output write_green, output write_blue,
                  output status, input ready);
  modport sink (input valid, input gain_red, input gain_green, input gain_blue,
                input write_red, input write_green, input write_blue,
                input status, output ready);
endinterface

// ===== rtl/wbg_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on wbg_pkg for the default width.
module wbg_div
  import wbg_pkg::*;
#(
  parameter int W = DIV_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic [W-1:0] quo_o
);

  // nq: numerator bits shifted out at the top, quotient bits shifted in below
  logic [W-1:0] nq  [0:W];
  logic [W-1:0] rem [0:W];
  logic [W-1:0] den [0:W];

  always_comb begin
    nq[0]  = num_i;
    rem[0] = '0;
    den[0] = den_i;
  end

  for (genvar s = 0; s < W; s++) begin : g_step
    logic [W:0] t;
    logic [W:0] diff;
    logic       ge;

    always_comb begin
      t    = {rem[s], nq[s][W-1]};
      diff = t - {1'b0, den[s]};
      ge   = (t >= {1'b0, den[s]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nq[s+1]  <= '0;
        rem[s+1] <= '0;
        den[s+1] <= '0;
      end else if (en_i) begin
        nq[s+1]  <= {nq[s][W-2:0], ge};
        rem[s+1] <= ge ? diff[W-1:0] : t[W-1:0];
        den[s+1] <= den[s];
      end
    end
  end

  assign quo_o = nq[W];

endmodule

// ===== rtl/wbg_delay.sv =====
// Enabled delay line that carries side data beside a divider.
// No dependencies.
module wbg_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [0:DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) tap_q[i] <= '0;
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

// ===== rtl/white_balance_gain_calculator.sv =====
// White balance gain calculator, top level.
// Depends on wbg_pkg, wbg_in_if, wbg_out_if, wbg_div, wbg_delay and the defines header.
//
// Usage:
//   in_i  carries one measured red/green/blue calibration triple per transaction.
//   out_o returns one result per input: three 12-bit gains (256 = unity), three
//         write flags (gain >= 256) and a status code; gains and flags are zero
//         unless status is ok.
//   cfg_*  write the typical red/green/blue gains (index 0..2, index 3 ignored);
//         write them only while no transaction is in flight.
// Throughput: one transaction per cycle. The whole pipeline advances together
// whenever the output register is empty or being taken, so in_i.ready follows
// out_o.ready (or an empty output register).
// Pipeline: input register, three chained 32-stage bit-serial
// dividers (ratios, first gain, dependent gain), two select/multiply stages,
// one post-multiply stage and the rounding/output register. The three divider
// chains produce one quotient bit per stage.
// Reset: all valid bits clear, typical gains return to their defaults.
// Stall: while out_o is valid and not ready, every stage holds; nothing is lost
// or repeated.
`include "white_balance_gain_calculator_defines.svh"

module white_balance_gain_calculator
  import wbg_pkg::*;
#(
  parameter int RATIO_SCALE_LOG2 = RATIO_SCALE_LOG2_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wbg_in_if.sink      in_i,
  wbg_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int          SH    = RATIO_SCALE_LOG2 - 8;
  localparam logic [31:0] SCALE = 32'(64'd1 << RATIO_SCALE_LOG2);
  localparam logic [31:0] HALF  = 32'((64'd1 << SH) >> 1);

  // ---------------- configuration registers
  logic [15:0] typ_red_q, typ_green_q, typ_blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      typ_red_q   <= RESET_TYP_RED;
      typ_green_q <= RESET_TYP_GREEN;
      typ_blue_q  <= RESET_TYP_BLUE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TYP_RED:   typ_red_q   <= cfg_data_i;
        CFG_TYP_GREEN: typ_green_q <= cfg_data_i;
        CFG_TYP_BLUE:  typ_blue_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- global advance
  logic out_valid_q;
  logic adv;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // ---------------- stage A: input register
  logic        va_q;
  logic [15:0] mr_q, mg_q, mb_q, tr_q, tg_q, tb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mr_q <= in_i.meas_red;
      mg_q <= in_i.meas_green;
      mb_q <= in_i.meas_blue;
      tr_q <= typ_red_q;
      tg_q <= typ_green_q;
      tb_q <= typ_blue_q;
    end
  end

  side1_t side_a, side_a_dly;
  assign side_a.valid = va_q;
  assign side_a.zero  = (mr_q == '0) || (mg_q == '0) || (mb_q == '0) ||
                        (tr_q == '0) || (tg_q == '0) || (tb_q == '0);

  logic [31:0] rg, bg, rgt, bgt;

  wbg_div #(.W(DIV_W)) u_div_rg (
    .clk_i, .rst_ni, .en_i(adv),
    .num_i({16'd0, mr_q} << RATIO_SCALE_LOG2), .den_i({16'd0, mg_q}), .quo_o(rg));
  wbg_div #(.W(DIV_W)) u_div_bg (
    .clk_i, .rst_ni, .en_i(adv),
    .num_i({16'd0, mb_q} << RATIO_SCALE_LOG2), .den_i({16'd0, mg_q}), .quo_o(bg));
  wbg_div #(.W(DIV_W)) u_div_rgt (
    .clk_i, .rst_ni, .en_i(adv),
    .num_i({16'd0, tr_q} << RATIO_SCALE_LOG2), .den_i({16'd0, tg_q}), .quo_o(rgt));
  wbg_div #(.W(DIV_W)) u_div_bgt (
    .clk_i, .rst_ni, .en_i(adv),
    .num_i({16'd0, tb_q} << RATIO_SCALE_LOG2), .den_i({16'd0, tg_q}), .quo_o(bgt));

  wbg_delay #(.W($bits(side1_t)), .DEPTH(DIV_W)) u_dly_a (
    .clk_i, .rst_ni, .en_i(adv), .d_i(side_a), .q_o(side_a_dly));

  // ---------------- stage B1: cross products of the ratios
  logic        vb_q, zb_q;
  logic [31:0] rg_q, bg_q, rgt_q, bgt_q, p1_q, p2_q;
  logic [63:0] p1_full, p2_full;

  assign p1_full = rg * bgt;
  assign p2_full = bg * rgt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= side_a_dly.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zb_q  <= side_a_dly.zero;
      rg_q  <= rg;
      bg_q  <= bg;
      rgt_q <= rgt;
      bgt_q <= bgt;
      p1_q  <= p1_full[31:0];
      p2_q  <= p2_full[31:0];
    end
  end

  // ---------------- stage B2: branch select, operands of the next divisions
  side2_t      side_b_d, side_b_q, side_b_dly;
  logic [31:0] n1_d, d1_d, n2_d, d2_d, n1_q, d1_q, n2_q, d2_q;

  always_comb begin
    side_b_d.valid = vb_q;
    if (zb_q) begin
      side_b_d.status = ST_ZERO_GAIN;
    end else if ((rg_q == '0) || (bg_q == '0) || (rgt_q == '0) || (bgt_q == '0)) begin
      side_b_d.status = ST_ZERO_RATIO;
    end else begin
      side_b_d.status = ST_OK;
    end
    n2_d = bg_q << RATIO_SCALE_LOG2;
    d2_d = bgt_q;
    if ((rg_q > rgt_q) && (bg_q > bgt_q)) begin
      side_b_d.branch = BR_GREEN;
      n1_d = rg_q << RATIO_SCALE_LOG2;
      d1_d = rgt_q;
    end else if (p1_q < p2_q) begin
      side_b_d.branch = BR_RED;
      n1_d = rgt_q << RATIO_SCALE_LOG2;
      d1_d = rg_q;
    end else begin
      side_b_d.branch = BR_BLUE;
      n1_d = bgt_q << RATIO_SCALE_LOG2;
      d1_d = bg_q;
    end
    // operands of the dependent division: other = green * x / y
    side_b_d.mul_x = (side_b_d.branch == BR_RED) ? bg_q : rg_q;
    side_b_d.den_y = (side_b_d.branch == BR_RED) ? bgt_q : rgt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_b_q <= '0;
    end else if (adv) begin
      side_b_q <= side_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_q <= n1_d;
      d1_q <= d1_d;
      n2_q <= n2_d;
      d2_q <= d2_d;
    end
  end

  logic [31:0] q1, q2;

  wbg_div #(.W(DIV_W)) u_div_q1 (
    .clk_i, .rst_ni, .en_i(adv), .num_i(n1_q), .den_i(d1_q), .quo_o(q1));
  wbg_div #(.W(DIV_W)) u_div_q2 (
    .clk_i, .rst_ni, .en_i(adv), .num_i(n2_q), .den_i(d2_q), .quo_o(q2));

  wbg_delay #(.W($bits(side2_t)), .DEPTH(DIV_W)) u_dly_b (
    .clk_i, .rst_ni, .en_i(adv), .d_i(side_b_q), .q_o(side_b_dly));

  // ---------------- stage C1: green gain times the other ratio
  side3_t      side_c_d, side_c_q, side_c_dly;
  logic [63:0] prod_full;
  logic [31:0] prod_q, deny_q;

  assign prod_full       = q1 * side_b_dly.mul_x;
  assign side_c_d.valid  = side_b_dly.valid;
  assign side_c_d.status = side_b_dly.status;
  assign side_c_d.branch = side_b_dly.branch;
  assign side_c_d.q1     = q1;
  assign side_c_d.q2     = q2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_c_q <= '0;
    end else if (adv) begin
      side_c_q <= side_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_full[31:0];
      deny_q <= side_b_dly.den_y;
    end
  end

  logic [31:0] q3;

  wbg_div #(.W(DIV_W)) u_div_q3 (
    .clk_i, .rst_ni, .en_i(adv), .num_i(prod_q), .den_i(deny_q), .quo_o(q3));

  wbg_delay #(.W($bits(side3_t)), .DEPTH(DIV_W)) u_dly_c (
    .clk_i, .rst_ni, .en_i(adv), .d_i(side_c_q), .q_o(side_c_dly));

  // ---------------- final: assemble, round to 256 scale, range check
  logic [31:0] r_raw, g_raw, b_raw, r_sum, g_sum, b_sum, r_rnd, g_rnd, b_rnd;
  status_e     st_fin;

  always_comb begin
    case (side_c_dly.branch)
      BR_GREEN: begin
        r_raw = side_c_dly.q1;
        g_raw = SCALE;
        b_raw = side_c_dly.q2;
      end
      BR_RED: begin
        r_raw = SCALE;
        g_raw = side_c_dly.q1;
        b_raw = q3;
      end
      default: begin
        r_raw = q3;
        g_raw = side_c_dly.q1;
        b_raw = SCALE;
      end
    endcase
    // the add wraps at 32 bits before the shift
    r_sum = r_raw + HALF;
    g_sum = g_raw + HALF;
    b_sum = b_raw + HALF;
    r_rnd = r_sum >> SH;
    g_rnd = g_sum >> SH;
    b_rnd = b_sum >> SH;
    if (side_c_dly.status != ST_OK) begin
      st_fin = side_c_dly.status;
    end else if ((r_rnd >= GAIN_LIMIT) || (g_rnd >= GAIN_LIMIT) || (b_rnd >= GAIN_LIMIT)) begin
      st_fin = ST_RANGE;
    end else begin
      st_fin = ST_OK;
    end
  end

  logic [11:0] gain_red_q, gain_green_q, gain_blue_q;
  logic        write_red_q, write_green_q, write_blue_q;
  status_e     status_q;
  logic        ok_fin;

  assign ok_fin = (st_fin == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= side_c_dly.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gain_red_q    <= ok_fin ? r_rnd[11:0] : '0;
      gain_green_q  <= ok_fin ? g_rnd[11:0] : '0;
      gain_blue_q   <= ok_fin ? b_rnd[11:0] : '0;
      write_red_q   <= ok_fin && (r_rnd >= GAIN_UNITY);
      write_green_q <= ok_fin && (g_rnd >= GAIN_UNITY);
      write_blue_q  <= ok_fin && (b_rnd >= GAIN_UNITY);
      status_q      <= st_fin;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.gain_red    = gain_red_q;
  assign out_o.gain_green  = gain_green_q;
  assign out_o.gain_blue   = gain_blue_q;
  assign out_o.write_red   = write_red_q;
  assign out_o.write_green = write_green_q;
  assign out_o.write_blue  = write_blue_q;
  assign out_o.status      = status_q;

  // ---------------- assertions
  `WBG_ASSERT_IMP(a_err_zero_gains, out_valid_q && (status_q != ST_OK),
                  (gain_red_q == '0) && (gain_green_q == '0) && (gain_blue_q == '0))
  `WBG_ASSERT_IMP(a_write_flags, out_valid_q,
                  (write_red_q == (gain_red_q >= 12'd256)) &&
                  (write_green_q == (gain_green_q >= 12'd256)) &&
                  (write_blue_q == (gain_blue_q >= 12'd256)))
  `WBG_ASSERT_NEXT(a_stall_holds_front, !adv, $stable(va_q) && $stable(side_b_q))

endmodule

// ===== dv/white_balance_gain_calculator_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the white balance gain calculator: directed and random calibration
// triples, a ratio/gain predictor and an in-order scoreboard. Depends on wbg_pkg,
// wbg_in_if, wbg_out_if and the RTL top level.
module white_balance_gain_calculator_tb;
  import wbg_pkg::*;

  localparam int SCALE_LOG2 = RATIO_SCALE_LOG2_DEF;
  localparam int LATENCY    = 101;

  typedef struct packed {
    logic [11:0] gain_red;
    logic [11:0] gain_green;
    logic [11:0] gain_blue;
    logic        write_red;
    logic        write_green;
    logic        write_blue;
    status_e     status;
  } wb_result_t;

  // Typical gains as the block holds them.
  logic [15:0] typ_red, typ_green, typ_blue;

  // Ratio num/den on the 2^SCALE_LOG2 scale; all arithmetic wraps at 32 bits.
  function automatic logic [31:0] scaled_ratio(logic [31:0] num, logic [31:0] den);
    logic [31:0] prod;
    prod = num << SCALE_LOG2;
    if (den == 0) return 0;
    return prod / den;
  endfunction

  function automatic logic [31:0] round_to_256(logic [31:0] g);
    int unsigned sh;
    logic [31:0] half;
    sh = SCALE_LOG2 - 8;
    half = (32'd1 << sh) >> 1;
    return (g + half) >> sh;
  endfunction

  function automatic wb_result_t predict_gains(logic [15:0] mr, logic [15:0] mg,
                                                logic [15:0] mb);
    wb_result_t res;
    logic [31:0] scale, rg, bg, rgt, bgt, r, g, b, p1, p2;
    res = '0;
    res.status = ST_OK;
    scale = 32'd1 << SCALE_LOG2;
    if (mr == 0 || mg == 0 || mb == 0 || typ_red == 0 || typ_green == 0 ||
        typ_blue == 0) begin
      res.status = ST_ZERO_GAIN;
      return res;
    end
    rg  = scaled_ratio(mr, mg);
    bg  = scaled_ratio(mb, mg);
    rgt = scaled_ratio(typ_red, typ_green);
    bgt = scaled_ratio(typ_blue, typ_green);
    if (rg == 0 || bg == 0 || rgt == 0 || bgt == 0) begin
      res.status = ST_ZERO_RATIO;
      return res;
    end
    p1 = rg * bgt;
    p2 = bg * rgt;
    if (rg > rgt && bg > bgt) begin
      g = scale;
      p1 = scale * rg;
      r = p1 / rgt;
      p2 = scale * bg;
      b = p2 / bgt;
    end else if (p1 < p2) begin
      r = scale;
      p1 = scale * rgt;
      g = p1 / rg;
      p2 = g * bg;
      b = p2 / bgt;
    end else begin
      b = scale;
      p1 = scale * bgt;
      g = p1 / bg;
      p2 = g * rg;
      r = p2 / rgt;
    end
    r = round_to_256(r);
    g = round_to_256(g);
    b = round_to_256(b);
    if (r >= GAIN_LIMIT || g >= GAIN_LIMIT || b >= GAIN_LIMIT) begin
      res.status = ST_RANGE;
      return res;
    end
    res.gain_red    = r[11:0];
    res.gain_green  = g[11:0];
    res.gain_blue   = b[11:0];
    res.write_red   = r >= GAIN_UNITY;
    res.write_green = g >= GAIN_UNITY;
    res.write_blue  = b >= GAIN_UNITY;
    return res;
  endfunction

  class gain_scoreboard;
    wb_result_t pending[$];
    int errors;

    function void note_input(wb_result_t exp_res);
      pending.push_back(exp_res);
    endfunction

    function void check_result(wb_result_t act);
      wb_result_t ex;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      ex = pending.pop_front();
      if (act.gain_red !== ex.gain_red) begin
        $error("gain_red exp %0d act %0d", ex.gain_red, act.gain_red); errors++;
      end
      if (act.gain_green !== ex.gain_green) begin
        $error("gain_green exp %0d act %0d", ex.gain_green, act.gain_green); errors++;
      end
      if (act.gain_blue !== ex.gain_blue) begin
        $error("gain_blue exp %0d act %0d", ex.gain_blue, act.gain_blue); errors++;
      end
      if (act.write_red !== ex.write_red) begin
        $error("write_red exp %0d act %0d", ex.write_red, act.write_red); errors++;
      end
      if (act.write_green !== ex.write_green) begin
        $error("write_green exp %0d act %0d", ex.write_green, act.write_green); errors++;
      end
      if (act.write_blue !== ex.write_blue) begin
        $error("write_blue exp %0d act %0d", ex.write_blue, act.write_blue); errors++;
      end
      if (act.status !== ex.status) begin
        $error("status exp %0d act %0d", ex.status, act.status); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [15:0] cfg_data;
  int src_idle_pct, snk_idle_pct;
  gain_scoreboard sb;

  wbg_in_if  in_ch();
  wbg_out_if out_ch();

  white_balance_gain_calculator i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Generous cap: ~2000 items with worst stalls stay far below this.
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random back-pressure; results checked at the accepting edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_ch.gain_red, out_ch.gain_green, out_ch.gain_blue,
                        out_ch.write_red, out_ch.write_green, out_ch.write_blue,
                        out_ch.status});
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TYP_RED) typ_red = val;
    else if (idx == CFG_TYP_GREEN) typ_green = val;
    else if (idx == CFG_TYP_BLUE) typ_blue = val;
  endtask

  task automatic set_typicals(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    write_reg(CFG_TYP_RED, r);
    write_reg(CFG_TYP_GREEN, g);
    write_reg(CFG_TYP_BLUE, b);
  endtask

  // Sends one triple; valid stays up across back-to-back transactions.
  task automatic send_triple(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.meas_red   <= r;
    in_ch.meas_green <= g;
    in_ch.meas_blue  <= b;
    sb.note_input(predict_gains(r, g, b));
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Mostly near the typical scale so the gain branches are reached; some raw 16-bit.
  function automatic logic [15:0] rand_meas(logic [15:0] typ);
    int sel;
    sel = $urandom_range(99);
    if (sel < 2) return '0;
    if (sel < 25) return 16'($urandom_range(65535));
    return 16'($urandom_range(typ / 2 + 1, typ + typ / 2 + 1));
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) begin
      send_triple(rand_meas(typ_red), rand_meas(typ_green), rand_meas(typ_blue));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    cfg_we = 0; cfg_idx = '0; cfg_data = '0;
    in_ch.valid = 0; in_ch.meas_red = 0; in_ch.meas_green = 0; in_ch.meas_blue = 0;
    out_ch.ready = 0;
    typ_red = RESET_TYP_RED; typ_green = RESET_TYP_GREEN; typ_blue = RESET_TYP_BLUE;
    src_idle_pct = 29; snk_idle_pct = 56;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset typicals, zeros, extremes, each branch, range overflow.
    send_triple(16'd3276, 16'd1756, 16'd2759);
    send_triple(16'd0, 16'd1756, 16'd2759);
    send_triple(16'd3276, 16'd0, 16'd2759);
    send_triple(16'd3276, 16'd1756, 16'd0);
    send_triple(16'hffff, 16'hffff, 16'hffff);
    send_triple(16'd1, 16'hffff, 16'd1);      // ratios truncate to zero
    send_triple(16'd1, 16'd1, 16'd1);
    send_triple(16'hffff, 16'd1, 16'hffff);   // products wrap
    send_triple(16'd4000, 16'd1756, 16'd3000); // both ratios above typical
    send_triple(16'd2000, 16'd1756, 16'd2759); // red weakest
    send_triple(16'd3276, 16'd1756, 16'd1500); // blue weakest
    send_triple(16'd100, 16'd1756, 16'd2759);  // gain out of range
    send_triple(16'd3276, 16'd1756, 16'd2758);
    send_triple(16'haaaa, 16'h5555, 16'haaaa);
    send_triple(16'h5555, 16'haaaa, 16'h5555);
    drain();
    write_reg(2'd3, 16'h1234);                 // ignored index
    set_typicals(16'd0, 16'd1756, 16'd2759);
    send_triple(16'd3276, 16'd1756, 16'd2759);
    drain();
    set_typicals(16'd1, 16'hffff, 16'd1);      // typical ratios zero
    send_triple(16'd3276, 16'd1756, 16'd2759);
    drain();
    set_typicals(16'hffff, 16'hffff, 16'hffff);
    send_triple(16'hffff, 16'hfffe, 16'hffff);
    send_triple(16'd1, 16'd1, 16'd1);
    drain();

    // Random phases across settings and idle profiles.
    set_typicals(RESET_TYP_RED, RESET_TYP_GREEN, RESET_TYP_BLUE);
    random_run(300);
    drain();
    src_idle_pct = 56; snk_idle_pct = 29;
    set_typicals(16'hffff, 16'h8000, 16'h0001);
    random_run(250);
    drain();
    set_typicals(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                 16'($urandom_range(1, 65535)));
    random_run(300);
    drain();
    src_idle_pct = 0; snk_idle_pct = 0;
    set_typicals(16'd1, 16'd1, 16'd1);
    random_run(250);
    drain();
    set_typicals(16'd3000, 16'd2000, 16'd2500);
    random_run(500);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wbg_pkg.sv
rtl/wbg_in_if.sv
rtl/wbg_out_if.sv
rtl/wbg_div.sv
rtl/wbg_delay.sv
rtl/white_balance_gain_calculator.sv
dv/white_balance_gain_calculator_tb.sv
